/* src/ray_box_slab_intersect_top_assert.svh */
// Assertion macros shared by the ray/box intersection block.
`ifndef RAY_BOX_SLAB_INTERSECT_TOP_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBSI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBSI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rbsi_pkg.sv */
`timescale 1ns / 1ps

package rbsi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5
    } cfg_index_t;

endpackage

/* src/rbsi_slab_div.sv */
`timescale 1ns / 1ps

// Pipelined signed divider, one quotient bit per stage, quotient truncated
// toward zero and saturated to DEN_W signed bits.
// Registers run from an input stage through the step stages to an output register, and advance only while en is high.
module rbsi_slab_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 32
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic signed [DEN_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [0:NUM_W];
    logic [NUM_W-1:0] q_reg   [0:NUM_W];
    logic [DEN_W-1:0] den_reg [0:NUM_W];
    logic             neg_reg [0:NUM_W];
    logic signed [DEN_W-1:0] quo_reg;
    logic signed [DEN_W-1:0] quo_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            q_reg[0]   <= num[NUM_W-1] ? (-num) : num;
            den_reg[0] <= den[DEN_W-1] ? (-den) : den;
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
        end
    end

    for (genvar k = 1; k <= NUM_W; k++) begin : g_step
        logic [DEN_W:0]   sh;
        logic [DEN_W+1:0] diff;
        logic             ge;

        always_comb begin
            sh   = {rem_reg[k-1], q_reg[k-1][NUM_W-1]};
            diff = {1'b0, sh} - {2'b00, den_reg[k-1]};
            ge   = !diff[DEN_W+1];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
                q_reg[k]   <= {q_reg[k-1][NUM_W-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    always_comb begin
        logic [NUM_W-1:0] mag;
        mag = q_reg[NUM_W];
        if (neg_reg[NUM_W]) begin
            if ((|mag[NUM_W-1:DEN_W]) || (mag[DEN_W-1] && (|mag[DEN_W-2:0]))) begin
                quo_next = {1'b1, {(DEN_W-1){1'b0}}};
            end else begin
                quo_next = -$signed(mag[DEN_W-1:0]);
            end
        end else begin
            if (|mag[NUM_W-1:DEN_W-1]) begin
                quo_next = {1'b0, {(DEN_W-1){1'b1}}};
            end else begin
                quo_next = $signed(mag[DEN_W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

/* src/ray_box_slab_intersect_top.sv */
`timescale 1ns / 1ps

// Ray against axis-aligned box, slab method, signed fixed point.
//
// Requests arrive on the s_ stream: one ray per request, packed in s_tdata.
// Results leave on the m_ stream, one per request and in the same order,
// with a hit flag and the narrowed entry and exit parameters.
// The box corners are written through the cfg_ channel, which is always
// ready; write it only while no request is in flight.
//
// Throughput is one request per cycle while the output is not stalled.
// Stages in order: one input register, the bit-per-stage slab dividers
// (one stage per numerator bit plus two), then narrowing, interval,
// multiply, point and compare stages. The dividers are the deepest part.
//
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and clears the box
// to zero.
module ray_box_slab_intersect_top #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF,
    localparam int CW         = COORD_WIDTH,
    localparam int IN_W       = 8 * CW,
    localparam int OUT_BITS   = 2 * CW + 1,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata, low bit up: origin_x, origin_y, origin_z, dir_x, dir_y,
    // dir_z, t_start, t_stop
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [IN_W-1:0]                   s_tdata,
    // m_tdata, low bit up: hit, t_enter, t_exit, zero padding
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_W-1:0]                  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbsi_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CW-1:0]                     cfg_data
);

`include "ray_box_slab_intersect_top_assert.svh"

    localparam int NUM_W   = CW + 1 + FRAC_BITS;
    localparam int DIV_LAT = NUM_W + 2;
    localparam int PW      = 2 * CW;

    typedef struct packed {
        logic [2:0][CW-1:0] org;
        logic [2:0][CW-1:0] dir;
        logic [CW-1:0]      t0;
        logic [CW-1:0]      t1;
    } item_t;

    logic signed [CW-1:0] box_min_reg [3];
    logic signed [CW-1:0] box_max_reg [3];

    logic en;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Box registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (rbsi_pkg::cfg_index_t'(cfg_index))
                rbsi_pkg::REG_BOX_MIN_X: box_min_reg[0] <= cfg_data;
                rbsi_pkg::REG_BOX_MIN_Y: box_min_reg[1] <= cfg_data;
                rbsi_pkg::REG_BOX_MIN_Z: box_min_reg[2] <= cfg_data;
                rbsi_pkg::REG_BOX_MAX_X: box_max_reg[0] <= cfg_data;
                rbsi_pkg::REG_BOX_MAX_Y: box_max_reg[1] <= cfg_data;
                rbsi_pkg::REG_BOX_MAX_Z: box_max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    logic  p0_valid_reg;
    item_t p0_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
        end else if (en) begin
            p0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                p0_item_reg.org[a] <= s_tdata[a*CW +: CW];
                p0_item_reg.dir[a] <= s_tdata[(3+a)*CW +: CW];
            end
            p0_item_reg.t0 <= s_tdata[6*CW +: CW];
            p0_item_reg.t1 <= s_tdata[7*CW +: CW];
        end
    end

    // Slab dividers, two per axis, with the ray riding alongside.
    logic signed [CW-1:0] q_lo [3];
    logic signed [CW-1:0] q_hi [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [CW:0]    d_lo;
        logic signed [CW:0]    d_hi;
        logic signed [NUM_W-1:0] n_lo;
        logic signed [NUM_W-1:0] n_hi;

        always_comb begin
            d_lo = {box_min_reg[a][CW-1], box_min_reg[a]}
                 - {p0_item_reg.org[a][CW-1], p0_item_reg.org[a]};
            d_hi = {box_max_reg[a][CW-1], box_max_reg[a]}
                 - {p0_item_reg.org[a][CW-1], p0_item_reg.org[a]};
            n_lo = {d_lo, {FRAC_BITS{1'b0}}};
            n_hi = {d_hi, {FRAC_BITS{1'b0}}};
        end

        rbsi_slab_div #(.NUM_W(NUM_W), .DEN_W(CW)) u_div_lo (
            .aclk (aclk),
            .en   (en),
            .num  (n_lo),
            .den  (p0_item_reg.dir[a]),
            .quo  (q_lo[a])
        );

        rbsi_slab_div #(.NUM_W(NUM_W), .DEN_W(CW)) u_div_hi (
            .aclk (aclk),
            .en   (en),
            .num  (n_hi),
            .den  (p0_item_reg.dir[a]),
            .quo  (q_hi[a])
        );
    end

    logic [DIV_LAT-1:0] dl_valid_reg;
    item_t              dl_item_reg [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dl_valid_reg <= '0;
        end else if (en) begin
            dl_valid_reg <= {dl_valid_reg[DIV_LAT-2:0], p0_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_item_reg[0] <= p0_item_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                dl_item_reg[k] <= dl_item_reg[k-1];
            end
        end
    end

    // Per-axis near and far; a zero direction leaves the interval alone.
    localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};

    logic                 n1_valid_reg;
    item_t                n1_item_reg;
    logic signed [CW-1:0] near_reg [3];
    logic signed [CW-1:0] far_reg  [3];
    logic signed [CW-1:0] near_next [3];
    logic signed [CW-1:0] far_next  [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (dl_item_reg[DIV_LAT-1].dir[a] == '0) begin
                near_next[a] = T_MIN;
                far_next[a]  = T_MAX;
            end else if (q_lo[a] < q_hi[a]) begin
                near_next[a] = q_lo[a];
                far_next[a]  = q_hi[a];
            end else begin
                near_next[a] = q_hi[a];
                far_next[a]  = q_lo[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n1_valid_reg <= 1'b0;
        end else if (en) begin
            n1_valid_reg <= dl_valid_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_item_reg <= dl_item_reg[DIV_LAT-1];
            for (int a = 0; a < 3; a++) begin
                near_reg[a] <= near_next[a];
                far_reg[a]  <= far_next[a];
            end
        end
    end

    // Narrowed interval, as a two-level max/min tree.
    logic                 n2_valid_reg;
    item_t                n2_item_reg;
    logic signed [CW-1:0] t0_reg, t1_reg;
    logic signed [CW-1:0] t0_next, t1_next;

    always_comb begin
        logic signed [CW-1:0] mx_a, mx_b, mn_a, mn_b;
        logic signed [CW-1:0] ts, te;
        ts   = n1_item_reg.t0;
        te   = n1_item_reg.t1;
        mx_a = (near_reg[0] > ts) ? near_reg[0] : ts;
        mx_b = (near_reg[2] > near_reg[1]) ? near_reg[2] : near_reg[1];
        mn_a = (far_reg[0] < te) ? far_reg[0] : te;
        mn_b = (far_reg[2] < far_reg[1]) ? far_reg[2] : far_reg[1];
        t0_next = (mx_b > mx_a) ? mx_b : mx_a;
        t1_next = (mn_b < mn_a) ? mn_b : mn_a;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n2_valid_reg <= 1'b0;
        end else if (en) begin
            n2_valid_reg <= n1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_item_reg <= n1_item_reg;
            t0_reg      <= t0_next;
            t1_reg      <= t1_next;
        end
    end

    // Direction times parameter at both ends.
    logic                 mu_valid_reg;
    logic                 mu_open_reg;
    logic [2:0][CW-1:0]   mu_org_reg;
    logic signed [CW-1:0] mu_t0_reg, mu_t1_reg;
    logic signed [PW-1:0] prod_a_reg [3];
    logic signed [PW-1:0] prod_b_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_valid_reg <= 1'b0;
        end else if (en) begin
            mu_valid_reg <= n2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mu_open_reg <= (t0_reg <= t1_reg);
            mu_org_reg  <= n2_item_reg.org;
            mu_t0_reg   <= t0_reg;
            mu_t1_reg   <= t1_reg;
            for (int a = 0; a < 3; a++) begin
                prod_a_reg[a] <= $signed(n2_item_reg.dir[a]) * t0_reg;
                prod_b_reg[a] <= $signed(n2_item_reg.dir[a]) * t1_reg;
            end
        end
    end

    // Ray points: floor shift, saturate, add origin, saturate.
    function automatic logic signed [CW-1:0] sat_wide(input logic signed [PW-1:0] v);
        logic pos_ovf, neg_ovf;
        pos_ovf = !v[PW-1] && (|v[PW-2:CW-1]);
        neg_ovf = v[PW-1] && !(&v[PW-2:CW-1]);
        if (pos_ovf) begin
            return T_MAX;
        end else if (neg_ovf) begin
            return T_MIN;
        end
        return v[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] point_of(input logic signed [CW-1:0] org,
                                                      input logic signed [PW-1:0] prod);
        logic signed [CW-1:0] ps;
        logic signed [CW:0]   sum;
        ps  = sat_wide(prod >>> FRAC_BITS);
        sum = {org[CW-1], org} + {ps[CW-1], ps};
        if (sum[CW] != sum[CW-1]) begin
            return sum[CW] ? T_MIN : T_MAX;
        end
        return sum[CW-1:0];
    endfunction

    logic                 pt_valid_reg;
    logic                 pt_open_reg;
    logic signed [CW-1:0] pt_t0_reg, pt_t1_reg;
    logic signed [CW-1:0] pa_reg [3];
    logic signed [CW-1:0] pb_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_valid_reg <= 1'b0;
        end else if (en) begin
            pt_valid_reg <= mu_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pt_open_reg <= mu_open_reg;
            pt_t0_reg   <= mu_t0_reg;
            pt_t1_reg   <= mu_t1_reg;
            for (int a = 0; a < 3; a++) begin
                pa_reg[a] <= point_of(mu_org_reg[a], prod_a_reg[a]);
                pb_reg[a] <= point_of(mu_org_reg[a], prod_b_reg[a]);
            end
        end
    end

    // Containment test and output register.
    logic                 out_valid_reg;
    logic                 hit_reg;
    logic signed [CW-1:0] enter_reg, exit_reg;
    logic                 hit_next;

    always_comb begin
        logic in_a, in_b;
        in_a = 1'b1;
        in_b = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (pa_reg[a] < box_min_reg[a] || pa_reg[a] > box_max_reg[a]) begin
                in_a = 1'b0;
            end
            if (pb_reg[a] < box_min_reg[a] || pb_reg[a] > box_max_reg[a]) begin
                in_b = 1'b0;
            end
        end
        hit_next = pt_open_reg && (in_a || in_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= pt_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg   <= hit_next;
            enter_reg <= hit_next ? pt_t0_reg : '0;
            exit_reg  <= hit_next ? pt_t1_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, exit_reg, enter_reg, hit_reg};

    // Checks.
    logic [DIV_LAT+5:0] pipe_valid;
    assign pipe_valid = {p0_valid_reg, dl_valid_reg, n1_valid_reg, n2_valid_reg,
                         mu_valid_reg, pt_valid_reg, out_valid_reg};

    `RBSI_ASSERT_NEXT(a_stall_freezes, aclk, aresetn, !en, $stable(pipe_valid),
        "pipeline moved during a stall")
    `RBSI_ASSERT_NOW(a_miss_zero, aclk, aresetn, out_valid_reg && !hit_reg,
        enter_reg == '0 && exit_reg == '0, "miss result carries nonzero parameters")
    `RBSI_ASSERT_NOW(a_hit_ordered, aclk, aresetn, out_valid_reg && hit_reg,
        enter_reg <= exit_reg, "hit with entry beyond exit")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int IN_W = 8 * CW;
    localparam int OUT_W = 72;
    localparam int LATENCY = CW + FB + 9;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [CW-1:0] t_stop;
        logic signed [CW-1:0] t_start;
        logic signed [CW-1:0] dir_z;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_x;
    } ray_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] t_enter;
        logic signed [CW-1:0] t_exit;
    } isect_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [rbsi_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;

    ray_box_slab_intersect_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Predictor copy of the box corners, index order as the register map.
    longint box_lo[3];
    longint box_hi[3];

    ray_t   ray_queue[$];
    isect_t isect_queue[$];
    int     send_idle_pct = 16;
    int     recv_idle_pct = 55;
    int     error_count = 0;
    int     quiet_cycles = 0;

    function automatic longint clamp_word(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // Slab bound crossing: scaled difference over the direction, truncated.
    function automatic longint slab_cross(longint bound, longint org, longint dir);
        longint num;
        num = (bound - org) * (64'sd1 <<< FB);
        return clamp_word(num / dir);
    endfunction

    // Ray point with the product floored at the fraction shift.
    function automatic longint ray_point(longint org, longint dir, longint t);
        longint prod;
        prod = dir * t;
        prod = prod >>> FB;
        return clamp_word(org + clamp_word(prod));
    endfunction

    function automatic isect_t predict_isect(ray_t r);
        longint org[3];
        longint dir[3];
        longint pa[3];
        longint pb[3];
        longint t0, t1, qa, qb;
        bit in_a, in_b;
        isect_t res;
        org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
        dir[0] = r.dir_x;    dir[1] = r.dir_y;    dir[2] = r.dir_z;
        t0 = r.t_start;
        t1 = r.t_stop;
        for (int a = 0; a < 3; a++) begin
            if (dir[a] != 0) begin
                qa = slab_cross(box_lo[a], org[a], dir[a]);
                qb = slab_cross(box_hi[a], org[a], dir[a]);
                if ((qa < qb ? qa : qb) > t0) t0 = (qa < qb ? qa : qb);
                if ((qa < qb ? qb : qa) < t1) t1 = (qa < qb ? qb : qa);
            end
        end
        res = '0;
        if (t0 <= t1) begin
            in_a = 1'b1;
            in_b = 1'b1;
            for (int a = 0; a < 3; a++) begin
                pa[a] = ray_point(org[a], dir[a], t0);
                pb[a] = ray_point(org[a], dir[a], t1);
                if (pa[a] < box_lo[a] || pa[a] > box_hi[a]) in_a = 1'b0;
                if (pb[a] < box_lo[a] || pb[a] > box_hi[a]) in_b = 1'b0;
            end
            if (in_a || in_b) begin
                res.hit = 1'b1;
                res.t_enter = t0[CW-1:0];
                res.t_exit = t1[CW-1:0];
            end
        end
        return res;
    endfunction

    // Driver: presents queued rays; valid is held until the request is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (ray_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata <= ray_queue[0];
                    isect_queue.push_back(predict_isect(ray_queue[0]));
                    void'(ray_queue.pop_front());
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        isect_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[2*CW:0];
                got.hit = m_tdata[0];
                got.t_enter = m_tdata[CW:1];
                got.t_exit = m_tdata[2*CW:CW+1];
                if (isect_queue.size() == 0) begin
                    $error("result with no request pending");
                    error_count++;
                end else begin
                    want = isect_queue.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit expected %0d got %0d", want.hit, got.hit);
                        error_count++;
                    end
                    if (got.t_enter !== want.t_enter) begin
                        $error("t_enter expected %0d got %0d", want.t_enter, got.t_enter);
                        error_count++;
                    end
                    if (got.t_exit !== want.t_exit) begin
                        $error("t_exit expected %0d got %0d", want.t_exit, got.t_exit);
                        error_count++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    task automatic write_box(rbsi_pkg::cfg_index_t idx, logic [CW-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx <= rbsi_pkg::REG_BOX_MAX_Z) begin
            if (idx < rbsi_pkg::REG_BOX_MAX_X) box_lo[idx] = $signed(val);
            else box_hi[idx - rbsi_pkg::REG_BOX_MAX_X] = $signed(val);
        end
    endtask

    task automatic load_box(logic [CW-1:0] lx, logic [CW-1:0] ly, logic [CW-1:0] lz,
                            logic [CW-1:0] hx, logic [CW-1:0] hy, logic [CW-1:0] hz);
        write_box(rbsi_pkg::REG_BOX_MIN_X, lx);
        write_box(rbsi_pkg::REG_BOX_MIN_Y, ly);
        write_box(rbsi_pkg::REG_BOX_MIN_Z, lz);
        write_box(rbsi_pkg::REG_BOX_MAX_X, hx);
        write_box(rbsi_pkg::REG_BOX_MAX_Y, hy);
        write_box(rbsi_pkg::REG_BOX_MAX_Z, hz);
    endtask

    // Waits until every request has been answered.
    task automatic drain();
        while (ray_queue.size() > 0 || s_tvalid || isect_queue.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [CW-1:0] rand_coord(int sel);
        unique case (sel)
            0: return $urandom();
            1: return CW'($signed($urandom_range(40 << FB)) - (20 << FB));
            2: return CW'($signed($urandom_range(1 << FB)) - (1 << (FB - 1)));
            default: return '0;
        endcase
    endfunction

    function automatic ray_t rand_ray();
        ray_t r;
        r.origin_x = rand_coord($urandom_range(3) == 0 ? 0 : 1);
        r.origin_y = rand_coord($urandom_range(3) == 0 ? 0 : 1);
        r.origin_z = rand_coord($urandom_range(3) == 0 ? 0 : 1);
        r.dir_x = rand_coord($urandom_range(4) == 0 ? 3 : $urandom_range(2));
        r.dir_y = rand_coord($urandom_range(4) == 0 ? 3 : $urandom_range(2));
        r.dir_z = rand_coord($urandom_range(4) == 0 ? 3 : $urandom_range(2));
        if ($urandom_range(4) == 0) begin
            r.t_start = $urandom();
            r.t_stop = $urandom();
        end else begin
            r.t_start = CW'(-$signed($urandom_range(8 << FB)));
            r.t_stop = CW'($urandom_range(60 << FB));
        end
        return r;
    endfunction

    initial begin
        ray_t r;
        box_lo = '{0, 0, 0};
        box_hi = '{0, 0, 0};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_box(CW'(-(4 << FB)), CW'(-(4 << FB)), CW'(-(4 << FB)),
                 CW'(4 << FB), CW'(4 << FB), CW'(4 << FB));
        // Out-of-map index must be ignored by the block.
        cfg_index <= 3'd7;
        cfg_data <= '1;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;

        // Directed: straight hit, all-zero direction, inverted interval,
        // ray outside, extremes of every field, saturation corners, a ray on a face.
        r = '0;
        r.origin_x = CW'(-(10 << FB)); r.dir_x = CW'(1 << FB);
        r.t_start = '0; r.t_stop = CW'(100 << FB);
        ray_queue.push_back(r);
        r = '0; r.t_stop = CW'(1 << FB);
        ray_queue.push_back(r);
        r.t_start = CW'(5 << FB); r.t_stop = CW'(1 << FB);
        ray_queue.push_back(r);
        r = '0; r.origin_y = CW'(50 << FB); r.dir_x = CW'(1 << FB);
        r.t_start = CW'(-(100 << FB)); r.t_stop = CW'(100 << FB);
        ray_queue.push_back(r);
        r = {8{32'h8000_0000}};
        ray_queue.push_back(r);
        r = {8{32'h7fff_ffff}};
        ray_queue.push_back(r);
        r = '0; r.dir_x = 32'h0000_0001; r.dir_y = 32'hffff_ffff; r.dir_z = 32'h8000_0000;
        r.t_start = 32'h8000_0000; r.t_stop = 32'h7fff_ffff;
        ray_queue.push_back(r);
        r = '1;
        ray_queue.push_back(r);
        r = '0; r.origin_z = CW'(4 << FB); r.dir_y = CW'(-(1 << FB));
        r.origin_y = CW'(10 << FB); r.t_stop = CW'(20 << FB);
        ray_queue.push_back(r);
        drain();

        // Inverted box: nothing can hit.
        load_box(CW'(4 << FB), '0, '0, CW'(-(4 << FB)), CW'(1 << FB), CW'(1 << FB));
        repeat (15) ray_queue.push_back(rand_ray());
        drain();

        // Extreme box corners.
        load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        repeat (60) ray_queue.push_back(rand_ray());
        r = {8{32'h8000_0000}};
        ray_queue.push_back(r);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 55; recv_idle_pct = 16;
            end else if (phase == 2) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            load_box(rand_coord(1), rand_coord(1), rand_coord(1),
                     CW'($urandom_range(20 << FB)), CW'($urandom_range(20 << FB)),
                     CW'($urandom_range(20 << FB)));
            for (int k = 0; k < 300; k++) ray_queue.push_back(rand_ray());
            drain();
        end

        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
